FILE: rtl/vwfd_pkg.sv
// Shared types, constants and helpers of the video write queue.
package vwfd_pkg;

	localparam int QUEUE_DEPTH   = 4;
	localparam int ENTRY_LATENCY = 2;
	localparam int DELAY_W       = 2;

	// Command codes
	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_DRAIN = 2'd2;

	// Destination codes
	localparam logic [3:0] DEST_VRAM_READ = 4'd0;
	localparam logic [3:0] DEST_VRAM      = 4'd1;
	localparam logic [3:0] DEST_CRAM      = 4'd3;
	localparam logic [3:0] DEST_VSRAM     = 4'd5;

	// Memory select codes
	localparam logic [1:0] MEM_SEL_VRAM  = 2'd0;
	localparam logic [1:0] MEM_SEL_CRAM  = 2'd1;
	localparam logic [1:0] MEM_SEL_VSRAM = 2'd2;

	localparam logic [1:0] DMA_MODE_FILL = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  write_target;
		logic [16:0] write_address;
		logic [15:0] write_word;
		logic        dma_busy;
		logic        dma_preloading;
		logic        command_pending;
		logic [1:0]  dma_mode;
	} in_item_t;

	typedef struct packed {
		logic        push_accepted;
		logic        drain_worked;
		logic        mem_write_valid;
		logic [1:0]  mem_select;
		logic [16:0] mem_address;
		logic [15:0] mem_data;
		logic        fill_capture_valid;
		logic [15:0] fill_data;
		logic        queue_empty;
		logic        queue_full;
	} out_item_t;

	typedef struct packed {
		logic [3:0]         dest;
		logic [16:0]        addr;
		logic [15:0]        word;
		logic               hi_pending;
		logic               lo_pending;
		logic [DELAY_W-1:0] delay;
	} slot_t;

	typedef slot_t [QUEUE_DEPTH-1:0] slot_vec_t;

	function automatic logic slot_empty(input slot_t s);
		return !s.hi_pending && !s.lo_pending;
	endfunction

endpackage

FILE: rtl/vwfd_step.sv
// One-pass update of the queue slots and result for a single command.
module vwfd_step import vwfd_pkg::*; (
	input  slot_vec_t slots,
	input  in_item_t  item,
	input  logic      vram_byte_mode,
	output slot_vec_t slots_next,
	output out_item_t res
);

	slot_t head;
	logic  found;
	logic  do_shift;
	logic  real_write;

	always_comb begin
		slots_next = slots;
		res        = '0;
		head       = slots[0];
		found      = 1'b0;
		do_shift   = 1'b0;
		real_write = 1'b0;
		case (item.command)
			CMD_PUSH: begin
				if (slot_empty(slots[QUEUE_DEPTH-1])) begin
					// take the first free slot
					for (int i = 0; i < QUEUE_DEPTH; i++) begin
						if (!found && slot_empty(slots[i])) begin
							slots_next[i].dest       = item.write_target;
							slots_next[i].addr       = item.write_address;
							slots_next[i].word       = item.write_word;
							slots_next[i].hi_pending = 1'b1;
							slots_next[i].lo_pending = 1'b1;
							slots_next[i].delay      = DELAY_W'(ENTRY_LATENCY);
							found = 1'b1;
						end
					end
					res.push_accepted = 1'b1;
				end
			end
			CMD_TICK: begin
				for (int i = 0; i < QUEUE_DEPTH; i++) begin
					if (!slot_empty(slots[i]) && slots[i].delay != '0)
						slots_next[i].delay = slots[i].delay - 1'b1;
				end
			end
			CMD_DRAIN: begin
				if (!slot_empty(slots[0]) && slots[0].delay == '0 &&
				    !(item.dma_busy && item.dma_preloading)) begin
					res.drain_worked = 1'b1;
					real_write = (head.dest == DEST_VRAM);
					if ((head.dest == DEST_VRAM || head.dest == DEST_VRAM_READ) &&
					    !vram_byte_mode) begin
						if (head.lo_pending) begin
							// low byte first, hold the entry at the head
							head.lo_pending = 1'b0;
							if (real_write) begin
								res.mem_write_valid = 1'b1;
								res.mem_select      = MEM_SEL_VRAM;
								res.mem_address     = head.addr ^ 17'd1;
								res.mem_data        = {8'h00, head.word[7:0]};
							end
						end else begin
							head.hi_pending = 1'b0;
							if (real_write) begin
								res.mem_write_valid = 1'b1;
								res.mem_select      = MEM_SEL_VRAM;
								res.mem_address     = head.addr;
								res.mem_data        = {8'h00, head.word[15:8]};
							end
							do_shift = 1'b1;
						end
					end else begin
						if (head.dest == DEST_VRAM && vram_byte_mode) begin
							res.mem_write_valid = 1'b1;
							res.mem_select      = MEM_SEL_VRAM;
							res.mem_address     = head.addr | 17'd1;
							res.mem_data        = {8'h00, head.word[7:0]};
						end else if (head.dest == DEST_CRAM) begin
							res.mem_write_valid = 1'b1;
							res.mem_select      = MEM_SEL_CRAM;
							res.mem_address     = {1'b0, head.addr[16:1]};
							res.mem_data        = head.word;
						end else if (head.dest == DEST_VSRAM) begin
							res.mem_write_valid = 1'b1;
							res.mem_select      = MEM_SEL_VSRAM;
							res.mem_address     = {1'b0, head.addr[16:1]};
							res.mem_data        = head.word;
						end
						head.lo_pending = 1'b0;
						head.hi_pending = 1'b0;
						do_shift = 1'b1;
					end
					slots_next[0] = head;
					if (do_shift) begin
						// late fetch: take the second slot unless the head is VRAM
						if (item.command_pending && item.dma_mode == DMA_MODE_FILL) begin
							res.fill_capture_valid = 1'b1;
							res.fill_data = (head.dest == DEST_VRAM) ? head.word : slots[1].word;
						end
						for (int i = 0; i < QUEUE_DEPTH - 1; i++)
							slots_next[i] = slots[i+1];
						slots_next[QUEUE_DEPTH-1] = head;
					end
				end
			end
			default: begin
			end
		endcase
		res.queue_empty = slot_empty(slots_next[0]);
		res.queue_full  = !slot_empty(slots_next[QUEUE_DEPTH-1]);
	end

endmodule

FILE: rtl/video_write_fifo_drain.sv
// Top level of the video write queue: input register, slot state and result register.
//
// A request (push, tick or drain attempt) is taken at any clock edge with start high;
// busy never rises, so one request per cycle is sustained. Each request gives exactly
// one result, shown on result with result_valid high for one cycle. The request is
// held in the input register, then the one-pass update of the four queue slots loads
// the result register. The receiver cannot stall and must take every result in the
// cycle it appears. The byte mode register is written through cfg_valid/cfg_data
// (cfg_ready is always high) and applies to requests taken at the same edge as the
// write or later. Reset empties the queue and clears the byte mode.
module video_write_fifo_drain import vwfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_data,
	output logic      result_valid,
	output out_item_t result
);

	in_item_t  item_s1;
	logic      valid_s1;
	slot_vec_t slots_q;
	slot_vec_t slots_next;
	logic      vram_byte_mode_q;
	out_item_t res_comb;
	out_item_t result_q;
	logic      result_valid_q;

	// Never hold off requests or configuration writes.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Capture the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// Byte mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vram_byte_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			vram_byte_mode_q <= cfg_data;
		end
	end

	vwfd_step u_step (
		.slots          (slots_q),
		.item           (item_s1),
		.vram_byte_mode (vram_byte_mode_q),
		.slots_next     (slots_next),
		.res            (res_comb)
	);

	// Advance the slots; reset clears contents too, since a fill may read a stale word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
		end else if (valid_s1) begin
			slots_q <= slots_next;
		end
	end

	// Result register: strobe for one cycle per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= res_comb;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Every accepted request yields its result through the input and result registers.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 result_valid)
		else $error("request without result");

	// Writes and fill captures only come from a drain step.
	a_write_needs_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.mem_write_valid || result.fill_capture_valid)
		|-> result.drain_worked)
		else $error("write or fill without drain step");

	// Occupied slots stay packed at the head.
	a_empty_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.queue_empty |-> !result.queue_full)
		else $error("queue empty and full at once");

	// An accepted push leaves the head occupied.
	a_push_fills_head: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.push_accepted |-> !result.queue_empty)
		else $error("accepted push left queue empty");

endmodule
